// ----- rtl/core/pdc_pkg.sv -----
// Package for the press duration classifier: item layouts, register indexes,
// reset values and the structs shared between the top level and the event queue.
// No dependencies.
package pdc_pkg;

  localparam int TIME_W            = 32;
  localparam int LOCKOUT_W         = 16;
  localparam int CLICK_W           = 16;
  localparam int HOLD_W            = 20;
  localparam int CFG_DATA_W        = 20;
  localparam int CFG_ADDR_W        = 2;
  localparam int EVENT_DEPTH_DEF   = 8;
  localparam int IN_TDATA_W        = 8;
  localparam int OUT_TDATA_W       = 8;

  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST    = LOCKOUT_W'(30);
  localparam logic [CLICK_W-1:0]   CLICK_MIN_RST  = CLICK_W'(50);
  localparam logic [HOLD_W-1:0]    SHORT_HOLD_RST = HOLD_W'(3000);
  localparam logic [HOLD_W-1:0]    LONG_HOLD_RST  = HOLD_W'(10000);

  // request flag bit positions
  localparam int REQ_CLICK = 0;
  localparam int REQ_SHORT = 1;
  localparam int REQ_LONG  = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LOCKOUT    = 2'd0,
    CFG_CLICK_MIN  = 2'd1,
    CFG_SHORT_HOLD = 2'd2,
    CFG_LONG_HOLD  = 2'd3
  } cfg_idx_t;

  // one queued level change: release flag and the tick it was seen on
  typedef struct packed {
    logic              is_release;
    logic [TIME_W-1:0] stamp;
  } event_t;

  // input item, pin_level in bit 0
  typedef struct packed {
    logic long_hold_ack;
    logic short_hold_ack;
    logic click_ack;
    logic busy_req;
    logic pin_level;
  } in_item_t;

  // result item, click_req in bit 0
  typedef struct packed {
    logic event_dropped;
    logic long_hold_ack_clear;
    logic short_hold_ack_clear;
    logic click_ack_clear;
    logic changed;
    logic long_hold_req;
    logic short_hold_req;
    logic click_req;
  } out_item_t;

  typedef struct packed {
    logic pop;
    logic push;
  } evq_ctrl_t;

  typedef struct packed {
    logic nonempty;
    logic room;   // space for a push after this cycle's pop
  } evq_stat_t;

endpackage

// ----- rtl/core/pdc_event_fifo.sv -----
// Event queue of the press duration classifier: a small circular buffer of
// timestamped press/release events with pop-before-push ordering.
// Depends on pdc_pkg.
module pdc_event_fifo #(
  parameter int DEPTH = pdc_pkg::EVENT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pdc_pkg::evq_ctrl_t  ctrl,
  input  pdc_pkg::event_t     push_data,
  output pdc_pkg::event_t     head_data,
  output pdc_pkg::evq_stat_t  stat
);
  import pdc_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  event_t           mem_r [DEPTH];
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, count_after_pop;
  logic [SUM_W-1:0] tail_sum;
  logic [IDX_W-1:0] tail;

  assign head_data       = mem_r[head_r];
  assign count_after_pop = count_r - CNT_W'(ctrl.pop);
  assign stat.nonempty   = (count_r != '0);
  assign stat.room       = (count_after_pop < CNT_W'(DEPTH));

  // old head plus old count gives the same slot as after the pop
  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(tail_sum);

  always_comb begin
    head_nxt = head_r;
    if (ctrl.pop) begin
      head_nxt = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
    end
    count_nxt = count_after_pop + CNT_W'(ctrl.push);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem_r[tail] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("event queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> count_r != '0)
    else $error("pop from empty event queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |-> stat.room)
    else $error("push into full event queue");

endmodule

// ----- rtl/core/press_duration_classifier.sv -----
// Press duration classifier: debounce lockout, event queue and click/short-hold/
// long-hold request handshake, one millisecond tick per input transfer.
// Results are registered: the input transfer is captured in the input register, then
// its result is captured in the result register.
// Throughput: one tick per cycle, the state update being a single pass of compares
// and two 32-bit subtractions. A result held by out_tready low stalls the input.
// Reset (rst_n low, synchronous) clears all control state and restores the
// register defaults; the event queue entries are not cleared.
module press_duration_classifier #(
  parameter int EVENT_DEPTH = pdc_pkg::EVENT_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] pin_level, [1] busy_req, [2] click_ack, [3] short_hold_ack,
  // [4] long_hold_ack, [7:5] zero
  input  logic [pdc_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] click_req, [1] short_hold_req, [2] long_hold_req, [3] changed,
  // [4] click_ack_clear, [5] short_hold_ack_clear, [6] long_hold_ack_clear,
  // [7] event_dropped
  output logic [pdc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [pdc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import pdc_pkg::*;

  // configuration
  logic [LOCKOUT_W-1:0] lockout_r;
  logic [CLICK_W-1:0]   click_min_r;
  logic [HOLD_W-1:0]    short_hold_r;
  logic [HOLD_W-1:0]    long_hold_r;

  // pipeline
  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  out_item_t  out_item_nxt;
  logic       adv_out;
  logic       s1_fire;

  // tick state
  logic [TIME_W-1:0] ms_r, ms_nxt;
  logic [TIME_W-1:0] last_edge_r, last_edge_nxt;
  logic              prev_level_r, prev_level_nxt;
  logic [TIME_W-1:0] press_start_r, press_start_nxt;
  logic              press_valid_r, press_valid_nxt;
  logic [2:0]        req_r, req_nxt;
  logic              chg_r, chg_nxt;

  // working values
  evq_ctrl_t         evq_ctrl;
  evq_stat_t         evq_stat;
  event_t            head_ev;
  event_t            push_ev;
  logic [TIME_W-1:0] dur;
  logic [TIME_W-1:0] since_edge;
  logic [2:0]        add;
  logic [2:0]        acks;
  logic [2:0]        req_mid;
  logic              chg_mid;
  logic [2:0]        strobes;
  logic              dropped;

  pdc_event_fifo #(
    .DEPTH(EVENT_DEPTH)
  ) u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (evq_ctrl),
    .push_data (push_ev),
    .head_data (head_ev),
    .stat      (evq_stat)
  );

  assign adv_out    = !out_valid_r || out_tready;
  assign s1_fire    = in_valid_r && adv_out;
  assign in_tready  = !in_valid_r || adv_out;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

  assign dur        = head_ev.stamp - press_start_r;
  assign since_edge = ms_r - last_edge_r;
  assign acks       = {in_item_r.long_hold_ack, in_item_r.short_hold_ack,
                       in_item_r.click_ack};
  assign push_ev    = '{is_release: in_item_r.pin_level, stamp: ms_r};

  always_comb begin
    evq_ctrl        = '0;
    press_start_nxt = press_start_r;
    press_valid_nxt = press_valid_r;
    last_edge_nxt   = last_edge_r;
    prev_level_nxt  = prev_level_r;
    ms_nxt          = ms_r;
    req_nxt         = req_r;
    chg_nxt         = chg_r;
    add             = '0;
    strobes         = '0;
    dropped         = 1'b0;

    // consume one queued event
    evq_ctrl.pop = s1_fire && !in_item_r.busy_req && evq_stat.nonempty;
    if (evq_ctrl.pop) begin
      if (!head_ev.is_release) begin
        press_start_nxt = head_ev.stamp;
        press_valid_nxt = 1'b1;
      end else if (press_valid_r) begin
        if (dur >= TIME_W'(long_hold_r)) begin
          add[REQ_LONG] = 1'b1;
        end else if (dur >= TIME_W'(short_hold_r)) begin
          add[REQ_SHORT] = 1'b1;
        end else if (dur >= TIME_W'(click_min_r)) begin
          add[REQ_CLICK] = 1'b1;
        end
        press_valid_nxt = 1'b0;
        press_start_nxt = '0;
      end
    end
    req_mid = req_r | add;
    chg_mid = chg_r || (add != '0);

    // queue a level change outside the lockout window
    if (s1_fire && (in_item_r.pin_level != prev_level_r)) begin
      prev_level_nxt = in_item_r.pin_level;
      if (since_edge >= TIME_W'(lockout_r)) begin
        last_edge_nxt = ms_r;
        if (evq_stat.room) begin
          evq_ctrl.push = 1'b1;
        end else begin
          dropped = 1'b1;
        end
      end
    end

    // request/ack handshake
    if (s1_fire) begin
      req_nxt = req_mid;
      chg_nxt = chg_mid;
      if (!in_item_r.busy_req && chg_mid) begin
        strobes = req_mid & acks;
        req_nxt = req_mid & ~strobes;
        if (req_nxt == '0) begin
          chg_nxt = 1'b0;
        end
      end
      ms_nxt = ms_r + TIME_W'(1);
    end

    out_item_nxt.click_req            = req_nxt[REQ_CLICK];
    out_item_nxt.short_hold_req       = req_nxt[REQ_SHORT];
    out_item_nxt.long_hold_req        = req_nxt[REQ_LONG];
    out_item_nxt.changed              = chg_nxt;
    out_item_nxt.click_ack_clear      = strobes[REQ_CLICK];
    out_item_nxt.short_hold_ack_clear = strobes[REQ_SHORT];
    out_item_nxt.long_hold_ack_clear  = strobes[REQ_LONG];
    out_item_nxt.event_dropped        = dropped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r    <= LOCKOUT_RST;
      click_min_r  <= CLICK_MIN_RST;
      short_hold_r <= SHORT_HOLD_RST;
      long_hold_r  <= LONG_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_LOCKOUT:    lockout_r    <= cfg_wdata[LOCKOUT_W-1:0];
        CFG_CLICK_MIN:  click_min_r  <= cfg_wdata[CLICK_W-1:0];
        CFG_SHORT_HOLD: short_hold_r <= cfg_wdata[HOLD_W-1:0];
        CFG_LONG_HOLD:  long_hold_r  <= cfg_wdata[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      ms_r          <= '0;
      last_edge_r   <= '0;
      prev_level_r  <= 1'b1;
      press_start_r <= '0;
      press_valid_r <= 1'b0;
      req_r         <= '0;
      chg_r         <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv_out) begin
        out_valid_r <= in_valid_r;
      end
      ms_r          <= ms_nxt;
      last_edge_r   <= last_edge_nxt;
      prev_level_r  <= prev_level_nxt;
      press_start_r <= press_start_nxt;
      press_valid_r <= press_valid_nxt;
      req_r         <= req_nxt;
      chg_r         <= chg_nxt;
    end
  end

  // payload registers: hold while stalled
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_item_t'(in_tdata[$bits(in_item_t)-1:0]);
    end
    if (s1_fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  a_req_implies_changed: assert property (@(posedge clk) disable iff (!rst_n)
    (req_r != '0) |-> chg_r)
    else $error("request pending without changed flag");

  a_strobe_clears_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_item_r & {1'b0, out_item_r[6:4], 1'b0, out_item_r[6:4]})
                     & 8'h07) == 8'h00)
    else $error("ack clear strobe with its request still set");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(ms_r) && $stable(req_r) && $stable(press_valid_r))
    else $error("tick state moved without a tick");

  a_busy_no_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    in_item_r.busy_req |-> strobes == '0 && !evq_ctrl.pop)
    else $error("handshake or pop while consumer busy");

endmodule

// ----- bench/pdc_tick_checker.sv -----
// Checker for the press duration classifier: watches the tick, result and register
// write ports, predicts the flags of every tick and compares them with the results.
// Depends on pdc_pkg.
module pdc_tick_checker #(
  parameter int EVENT_DEPTH = pdc_pkg::EVENT_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [pdc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [pdc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [pdc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              mismatches,
  output int                              outstanding
);
  import pdc_pkg::*;

  localparam int PRINT_CAP = 40;

  string field_label [0:OUT_TDATA_W-1] = '{"click_req", "short_hold_req", "long_hold_req",
    "changed", "click_ack_clear", "short_hold_ack_clear", "long_hold_ack_clear",
    "event_dropped"};

  logic [LOCKOUT_W-1:0] lockout_cfg;
  logic [CLICK_W-1:0]   click_cfg;
  logic [HOLD_W-1:0]    short_cfg;
  logic [HOLD_W-1:0]    long_cfg;

  logic [TIME_W-1:0] clock_ms;
  logic [TIME_W-1:0] last_edge_ms;
  logic [TIME_W-1:0] press_ms;
  logic              level_seen;
  logic              press_held;
  logic [2:0]        pending_req;
  logic              changed_seen;
  event_t            edge_fifo [EVENT_DEPTH];
  int                fifo_count;
  int                fifo_head;

  out_item_t expected_flags [$];
  int        results_seen;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP)
      $display("%0t: result %0d: %s", $realtime, results_seen, what);
    mismatches++;
  endtask

  // One millisecond tick: pop one edge, queue this tick's edge, then run the handshake.
  task automatic classify_tick(input in_item_t tick, output out_item_t res);
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since_edge;
    logic [2:0]        acks;
    logic [2:0]        strobes;
    logic [2:0]        grade;
    logic              dropped;
    event_t            ev;
    now     = clock_ms;
    strobes = '0;
    dropped = 1'b0;
    acks    = '0;
    acks[REQ_CLICK] = tick.click_ack;
    acks[REQ_SHORT] = tick.short_hold_ack;
    acks[REQ_LONG]  = tick.long_hold_ack;

    if (!tick.busy_req && fifo_count > 0) begin
      ev = edge_fifo[fifo_head];
      fifo_head = (fifo_head + 1) % EVENT_DEPTH;
      fifo_count--;
      if (!ev.is_release) begin
        press_ms   = ev.stamp;
        press_held = 1'b1;
      end else if (press_held) begin
        held  = ev.stamp - press_ms;
        grade = '0;
        // long wins over short over click, whatever the register order
        if (held >= long_cfg)
          grade[REQ_LONG] = 1'b1;
        else if (held >= short_cfg)
          grade[REQ_SHORT] = 1'b1;
        else if (held >= click_cfg)
          grade[REQ_CLICK] = 1'b1;
        if (grade != '0) begin
          pending_req  = pending_req | grade;
          changed_seen = 1'b1;
        end
        press_held = 1'b0;
        press_ms   = '0;
      end
    end

    if (tick.pin_level != level_seen) begin
      level_seen = tick.pin_level;
      since_edge = now - last_edge_ms;
      if (since_edge >= TIME_W'(lockout_cfg)) begin
        // the lockout restarts even when the edge is dropped
        last_edge_ms = now;
        if (fifo_count < EVENT_DEPTH) begin
          edge_fifo[(fifo_head + fifo_count) % EVENT_DEPTH] = '{is_release: tick.pin_level,
                                                                stamp: now};
          fifo_count++;
        end else begin
          dropped = 1'b1;
        end
      end
    end

    if (!tick.busy_req && changed_seen) begin
      strobes     = pending_req & acks;
      pending_req = pending_req & ~strobes;
      if (pending_req == '0)
        changed_seen = 1'b0;
    end

    clock_ms = now + 1'b1;

    res.click_req            = pending_req[REQ_CLICK];
    res.short_hold_req       = pending_req[REQ_SHORT];
    res.long_hold_req        = pending_req[REQ_LONG];
    res.changed              = changed_seen;
    res.click_ack_clear      = strobes[REQ_CLICK];
    res.short_hold_ack_clear = strobes[REQ_SHORT];
    res.long_hold_ack_clear  = strobes[REQ_LONG];
    res.event_dropped        = dropped;
  endtask

  always @(posedge clk) begin
    out_item_t seen;
    out_item_t want;
    in_item_t  tick;
    if (!rst_n) begin
      lockout_cfg  = LOCKOUT_RST;
      click_cfg    = CLICK_MIN_RST;
      short_cfg    = SHORT_HOLD_RST;
      long_cfg     = LONG_HOLD_RST;
      clock_ms     = '0;
      last_edge_ms = '0;
      press_ms     = '0;
      level_seen   = 1'b1;
      press_held   = 1'b0;
      pending_req  = '0;
      changed_seen = 1'b0;
      fifo_count   = 0;
      fifo_head    = 0;
      results_seen = 0;
      expected_flags.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_LOCKOUT:    lockout_cfg = cfg_wdata[LOCKOUT_W-1:0];
          CFG_CLICK_MIN:  click_cfg   = cfg_wdata[CLICK_W-1:0];
          CFG_SHORT_HOLD: short_cfg   = cfg_wdata[HOLD_W-1:0];
          CFG_LONG_HOLD:  long_cfg    = cfg_wdata[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        seen = out_item_t'(out_tdata);
        if (expected_flags.size() == 0) begin
          report_mismatch($sformatf("transfer %b arrived with no tick waiting", out_tdata));
        end else begin
          want = expected_flags.pop_front();
          for (int b = 0; b < OUT_TDATA_W; b++)
            if (seen[b] !== want[b])
              report_mismatch($sformatf("%s is %b, predicted %b", field_label[b],
                                        seen[b], want[b]));
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        tick = in_item_t'(in_tdata[$bits(in_item_t)-1:0]);
        classify_tick(tick, want);
        expected_flags.push_back(want);
      end
    end
    outstanding <= expected_flags.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the press duration classifier bench: clock, reset, register settings and
// tick stimulus, with pdc_tick_checker beside the block checking every result.
// Depends on pdc_pkg, press_duration_classifier and pdc_tick_checker.
module testbench;
  import pdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CAP       = 60;

  localparam logic [2:0] ACK_NONE  = 3'b000;
  localparam logic [2:0] ACK_CLICK = 3'b001 << REQ_CLICK;
  localparam logic [2:0] ACK_SHORT = 3'b001 << REQ_SHORT;
  localparam logic [2:0] ACK_LONG  = 3'b001 << REQ_LONG;
  localparam logic [2:0] ACK_ALL   = ACK_CLICK | ACK_SHORT | ACK_LONG;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  bit steady       = 1'b0;

  // register values as last written, used to aim press lengths at the thresholds
  int lock_ms  = 30;
  int click_ms = 50;
  int short_ms = 3000;
  int long_ms  = 10000;

  // random gesture state
  logic pin       = 1'b1;
  int   hold_left = 0;
  int   busy_left = 0;

  press_duration_classifier uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  pdc_tick_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[press_duration_classifier] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input logic level, input logic busy, input logic [2:0] acks);
    in_item_t it;
    it.pin_level      = level;
    it.busy_req       = busy;
    it.click_ack      = acks[REQ_CLICK];
    it.short_hold_ack = acks[REQ_SHORT];
    it.long_hold_ack  = acks[REQ_LONG];
    if (!steady)
      while ($urandom_range(0, 99) < 25) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(it);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // drop valid and hold off until every predicted result has been transferred
  task automatic wait_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic write_settings(input int lockout, input int click, input int short_hold,
                                input int long_hold);
    put_reg(CFG_LOCKOUT, lockout);
    put_reg(CFG_CLICK_MIN, click);
    put_reg(CFG_SHORT_HOLD, short_hold);
    put_reg(CFG_LONG_HOLD, long_hold);
    cfg_we   <= 1'b0;
    lock_ms  = lockout;
    click_ms = click;
    short_ms = short_hold;
    long_ms  = long_hold;
  endtask

  // length of the next level run, at most HOLD_CAP: bounce, just around one of the thresholds, or random
  function automatic int next_hold();
    int len;
    case ($urandom_range(0, 9))
      0, 1, 2: len = $urandom_range(1, lock_ms + 2);
      3, 4:    len = click_ms - 1 + $urandom_range(0, 2);
      5, 6:    len = short_ms - 1 + $urandom_range(0, 2);
      7:       len = long_ms - 1 + $urandom_range(0, 2);
      default: len = $urandom_range(1, long_ms + 3);
    endcase
    if (len < 1)
      len = 1;
    if (len > HOLD_CAP)
      len = $urandom_range(1, HOLD_CAP);
    return len;
  endfunction

  task automatic run_phase(input int lockout, input int click, input int short_hold,
                           input int long_hold, input int ticks);
    logic [2:0] acks;
    wait_results();
    write_settings(lockout, click, short_hold, long_hold);
    for (int n = 0; n < ticks; n++) begin
      if (hold_left == 0) begin
        pin       = ~pin;
        hold_left = next_hold();
      end
      hold_left--;
      if (busy_left > 0)
        busy_left--;
      else if ($urandom_range(0, 9) == 0)
        busy_left = $urandom_range(1, 24);
      acks[REQ_CLICK] = ($urandom_range(0, 99) < 30);
      acks[REQ_SHORT] = ($urandom_range(0, 99) < 30);
      acks[REQ_LONG]  = ($urandom_range(0, 99) < 30);
      send_tick(pin, busy_left != 0, acks);
      if ($urandom_range(0, 199) == 0)
        wait_results();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults: changes inside the first lockout window are lost
    send_tick(1'b0, 1'b0, ACK_NONE);
    send_tick(1'b1, 1'b0, ACK_ALL);
    wait_results();

    write_settings(2, 3, 5, 8);
    send_tick(1'b0, 1'b0, ACK_NONE);   // press
    send_tick(1'b0, 1'b0, ACK_NONE);
    send_tick(1'b1, 1'b0, ACK_NONE);   // release below click minimum
    send_tick(1'b0, 1'b0, ACK_NONE);   // lost in lockout
    send_tick(1'b1, 1'b0, ACK_NONE);   // release with no press recorded
    send_tick(1'b1, 1'b0, ACK_NONE);
    send_tick(1'b0, 1'b0, ACK_NONE);   // press
    send_tick(1'b1, 1'b0, ACK_NONE);   // lost in lockout
    send_tick(1'b0, 1'b0, ACK_NONE);   // second press overwrites the start
    send_tick(1'b0, 1'b0, ACK_NONE);
    send_tick(1'b0, 1'b0, ACK_NONE);
    send_tick(1'b1, 1'b0, ACK_NONE);   // click
    send_tick(1'b1, 1'b1, ACK_CLICK);  // busy holds both the pop and the ack
    send_tick(1'b1, 1'b0, ACK_SHORT | ACK_LONG);
    send_tick(1'b1, 1'b0, ACK_CLICK);
    send_tick(1'b0, 1'b0, ACK_CLICK);  // ack with nothing pending
    repeat (7) send_tick(1'b0, 1'b0, ACK_NONE);
    send_tick(1'b1, 1'b0, ACK_SHORT);  // long hold
    send_tick(1'b1, 1'b0, ACK_LONG);

    run_phase(1, 1, 4, 10, 150);
    steady = 1'b1;
    run_phase(3, 5, 12, 25, 150);
    steady = 1'b0;
    run_phase(1, 20, 8, 4, 120);
    run_phase(0, 0, 0, 0, 100);
    run_phase(0, 0, 20'hFFFFF, 20'hFFFFF, 100);
    run_phase(16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 40);
    run_phase(0, 2, 6, 15, 150);
    run_phase(2, 3, 5, 8, 140);

    wait_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("[press_duration_classifier] OK");
    else
      $display("[press_duration_classifier] ERROR");
    $finish;
  end

endmodule
